// ===== design/plpa_pkg.sv =====
`timescale 1ns / 1ps

package plpa_pkg;

    // Coordinate format (Q15.8 by default; fraction bits do not change the logic)
    localparam int IN_BITS    = 24;
    localparam int COORD_BITS = 24;
    localparam int MAX_POINTS = 65535;

    // Datapath widths
    localparam int OP_BITS    = COORD_BITS + 1;          // coordinate difference
    localparam int PROD_BITS  = 2 * OP_BITS;             // product / squared distance
    localparam int ROOT_BITS  = OP_BITS;                 // isqrt of PROD_BITS radicand
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int ITER_BITS  = $clog2(ROOT_BITS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 2);
    localparam int LEN_BITS   = 48;
    localparam int AREA_BITS  = 63;
    localparam int CROSS_BITS = 64;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OP_BITS-1:0]    t_op;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [CROSS_BITS-1:0] t_cross;

    localparam t_cross CROSS_MAX = {1'b0, {(CROSS_BITS-1){1'b1}}};
    localparam t_cross CROSS_MIN = {1'b1, {(CROSS_BITS-1){1'b0}}};

    // Saturating add of one shoelace term into the signed accumulator
    function automatic t_cross sat_add_cross(t_cross acc, t_prod term);
        logic signed [CROSS_BITS:0] sum;
        sum = {acc[CROSS_BITS-1], acc}
            + {{(CROSS_BITS + 1 - PROD_BITS){term[PROD_BITS-1]}}, term};
        if (sum[CROSS_BITS] != sum[CROSS_BITS-1]) begin
            return sum[CROSS_BITS] ? CROSS_MIN : CROSS_MAX;
        end
        return sum[CROSS_BITS-1:0];
    endfunction

endpackage

// ===== design/polyline_length_polygon_area_unit.sv =====
`timescale 1ns / 1ps
// A result beat is loaded as the last vertex leaves the finish state.
// A new vertex is taken only when idle, after the last one ran 7 passes through the single
//   shared multiplier and the 2-bit-per-cycle square root (COORD_BITS+1 iterations).
// A waiting result beat does not block the next vertex; only a second result waits.
// Reset (synchronous, active low) clears the vertex count, accumulators and handshakes.
module polyline_length_polygon_area_unit
    import plpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // vertex channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IN_BITS-1:0]    i_point_x,
    input  logic [IN_BITS-1:0]    i_point_y,
    input  logic [IN_BITS-1:0]    i_point_z,
    input  logic                  i_last_point,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LEN_BITS-1:0]   o_path_length,
    output logic [AREA_BITS-1:0]  o_enclosed_area,
    output logic                  o_count_overflow
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // Multiplier passes, in issue order
    localparam logic [2:0] MP_DX   = 3'd0;  // dx*dx
    localparam logic [2:0] MP_DY   = 3'd1;  // dy*dy
    localparam logic [2:0] MP_DZ   = 3'd2;  // dz*dz
    localparam logic [2:0] MP_PXY  = 3'd3;  // prev.x*cur.y
    localparam logic [2:0] MP_PYX  = 3'd4;  // prev.y*cur.x
    localparam logic [2:0] MP_CXF  = 3'd5;  // cur.x*first.y
    localparam logic [2:0] MP_CYF  = 3'd6;  // cur.y*first.x
    localparam logic [2:0] MP_DRAIN = 3'd7;

    logic [1:0]            r_state;
    logic [2:0]            r_step;
    logic [ITER_BITS-1:0]  r_iter;

    // Polygon state
    t_coord                r_first_x, r_first_y;
    t_coord                r_prev_x, r_prev_y, r_prev_z;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [LEN_BITS-1:0]   r_len;
    t_cross                r_cross;

    // Current vertex
    t_coord                r_cur_x, r_cur_y, r_cur_z;
    t_op                   r_dx, r_dy, r_dz;
    logic                  r_last;
    logic                  r_seg;          // vertex closes a segment

    // Multiplier pipe
    t_prod                 r_prod;
    logic                  r_pv;
    logic [2:0]            r_ptag;
    t_prod                 r_term;
    logic [PROD_BITS-1:0]  r_sq;

    // Square root shift registers
    logic [PROD_BITS-1:0]  r_rad;
    logic [REM_BITS-1:0]   r_rem;
    logic [ROOT_BITS-1:0]  r_root;

    // Result register
    logic                  r_ovalid;
    logic [LEN_BITS-1:0]   r_olen;
    logic [AREA_BITS-1:0]  r_oarea;
    logic                  r_oovf;

    t_coord                in_x, in_y, in_z;
    t_op                   mul_a, mul_b;
    t_prod                 diff_term;
    logic [REM_BITS-1:0]   rem_sh, trial;
    logic                  root_bit;
    logic [REM_BITS-1:0]   n_rem;
    logic [ROOT_BITS-1:0]  n_root;
    logic [LEN_BITS:0]     len_sum;
    logic [LEN_BITS-1:0]   n_len;
    logic [CNT_BITS-1:0]   n_cnt;
    logic [CROSS_BITS-1:0] abs_cross;
    logic [AREA_BITS-1:0]  n_area;
    logic                  accept, fin_leave;

    assign in_x = i_point_x[COORD_BITS-1:0];
    assign in_y = i_point_y[COORD_BITS-1:0];
    assign in_z = i_point_z[COORD_BITS-1:0];

    assign o_in_ready       = (r_state == ST_IDLE);
    assign accept           = i_in_valid && o_in_ready;
    assign o_out_valid      = r_ovalid;
    assign o_path_length    = r_olen;
    assign o_enclosed_area  = r_oarea;
    assign o_count_overflow = r_oovf;

    // Shared multiplier operand select
    always_comb begin
        case (r_step)
            MP_DX: begin
                mul_a = r_dx;
                mul_b = r_dx;
            end
            MP_DY: begin
                mul_a = r_dy;
                mul_b = r_dy;
            end
            MP_DZ: begin
                mul_a = r_dz;
                mul_b = r_dz;
            end
            MP_PXY: begin
                mul_a = {r_prev_x[COORD_BITS-1], r_prev_x};
                mul_b = {r_cur_y[COORD_BITS-1], r_cur_y};
            end
            MP_PYX: begin
                mul_a = {r_prev_y[COORD_BITS-1], r_prev_y};
                mul_b = {r_cur_x[COORD_BITS-1], r_cur_x};
            end
            MP_CXF: begin
                mul_a = {r_cur_x[COORD_BITS-1], r_cur_x};
                mul_b = {r_first_y[COORD_BITS-1], r_first_y};
            end
            MP_CYF: begin
                mul_a = {r_cur_y[COORD_BITS-1], r_cur_y};
                mul_b = {r_first_x[COORD_BITS-1], r_first_x};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Cross term = first product minus second; magnitudes stay well inside PROD_BITS
    assign diff_term = r_term - r_prod;

    // One restoring square root digit: two radicand bits in, one root bit out
    assign rem_sh   = {r_rem[REM_BITS-3:0], r_rad[PROD_BITS-1 -: 2]};
    assign trial    = {r_root, 2'b01};
    assign root_bit = (rem_sh >= trial);
    assign n_rem    = root_bit ? (rem_sh - trial) : rem_sh;
    assign n_root   = {r_root[ROOT_BITS-2:0], root_bit};

    // Finish: saturating length add, count, absolute area
    assign len_sum = {1'b0, r_len} + {{(LEN_BITS + 1 - ROOT_BITS){1'b0}}, r_root};
    assign n_len   = !r_seg ? r_len : (len_sum[LEN_BITS] ? '1 : len_sum[LEN_BITS-1:0]);
    assign n_cnt   = (r_cnt <= CNT_BITS'(MAX_POINTS)) ? r_cnt + 1'b1 : r_cnt;
    assign abs_cross = r_cross[CROSS_BITS-1] ? (~r_cross + 1'b1) : r_cross;
    assign n_area    = abs_cross[CROSS_BITS-1] ? '1 : abs_cross[AREA_BITS-1:0];
    assign fin_leave = (r_state == ST_FIN) && (!r_last || !r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_iter    <= '0;
            r_pv      <= 1'b0;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_cross   <= '0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_prev_z  <= '0;
        end else begin
            // product pipe: issue in MUL, consume from the product register in the next cycle
            r_pv   <= (r_state == ST_MUL) && (r_step != MP_DRAIN);
            r_ptag <= r_step;
            r_prod <= mul_a * mul_b;

            if (r_pv) begin
                case (r_ptag)
                    MP_DX:         r_sq   <= r_prod;
                    MP_DY, MP_DZ:  r_sq   <= r_sq + r_prod;
                    MP_PXY:        r_term <= r_prod;
                    MP_PYX: begin
                        if (r_seg) begin
                            r_cross <= sat_add_cross(r_cross, diff_term);
                        end
                    end
                    MP_CXF:        r_term <= r_prod;
                    MP_CYF: begin
                        if (r_last) begin
                            r_cross <= sat_add_cross(r_cross, diff_term);
                        end
                    end
                    default: ;
                endcase
            end

            // result valid: a finishing last vertex loads a beat, else a taken beat clears
            if (fin_leave && r_last) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cur_x <= in_x;
                        r_cur_y <= in_y;
                        r_cur_z <= in_z;
                        r_dx    <= {in_x[COORD_BITS-1], in_x} - {r_prev_x[COORD_BITS-1], r_prev_x};
                        r_dy    <= {in_y[COORD_BITS-1], in_y} - {r_prev_y[COORD_BITS-1], r_prev_y};
                        r_dz    <= {in_z[COORD_BITS-1], in_z} - {r_prev_z[COORD_BITS-1], r_prev_z};
                        r_last  <= i_last_point;
                        r_seg   <= (r_cnt != '0);
                        if (r_cnt == '0) begin
                            r_first_x <= in_x;
                            r_first_y <= in_y;
                        end
                        r_step  <= MP_DX;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == MP_DRAIN) begin
                        // squares all summed by now; load the root unit
                        r_rad   <= r_sq;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_iter  <= '0;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_rad  <= {r_rad[PROD_BITS-3:0], 2'b00};
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_BITS'(ROOT_BITS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_leave) begin
                        r_state <= ST_IDLE;
                        if (r_last) begin
                            r_olen    <= n_len;
                            r_oarea   <= n_area;
                            r_oovf    <= (n_cnt > CNT_BITS'(MAX_POINTS));
                            r_cnt     <= '0;
                            r_len     <= '0;
                            r_cross   <= '0;
                            r_first_x <= '0;
                            r_first_y <= '0;
                            r_prev_x  <= '0;
                            r_prev_y  <= '0;
                            r_prev_z  <= '0;
                        end else begin
                            r_cnt    <= n_cnt;
                            r_len    <= n_len;
                            r_prev_x <= r_cur_x;
                            r_prev_y <= r_cur_y;
                            r_prev_z <= r_cur_z;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Root remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> (r_rem <= {1'b0, r_root, 1'b0}))
        else $error("square root remainder out of bound");

    // Products are only in flight while the multiplier is sequencing
    a_prod_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == ST_MUL))
        else $error("product pending outside multiply phase");

    // A finished last vertex always lands a result beat
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_leave && r_last) |=> o_out_valid)
        else $error("last vertex finished without a result beat");

    // No new vertex while one is in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_MUL) && !o_in_ready)
        else $error("vertex accepted while busy");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Polygon length/area unit bench.
// Vertices stream in on one valid/ready channel and results come back on another.
// A scoreboard tracks each polygon as its vertices are accepted. It computes the
// expected open-path length and shoelace area, and compares every result beat
// against the oldest outstanding polygon.
module tb_top;
    import plpa_pkg::*;

    localparam int     CLK_HALF    = 6;
    localparam int     RESET_CYCLES = 12;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 40;      // run on after the last result beat is checked
    localparam int     HOLD_CYCLES = 900;      // long output back-pressure window
    localparam int     TOTAL_VERTICES = 1100;
    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord COORD_ONE = t_coord'(256);  // 1.0 in Q15.8

    // coordinate styles for random polygons
    typedef enum int {
        STYLE_FULL    = 0,   // anywhere in the coordinate range
        STYLE_NEAR    = 1,   // within +/-16.0 of the origin in Q15.8
        STYLE_CORNERS = 2,   // extremes, zero, minus one, or any value
        STYLE_CLUSTER = 3    // tight group around a random center
    } t_coord_style;

    typedef struct packed {
        logic [LEN_BITS-1:0]  length;
        logic [AREA_BITS-1:0] area;
        logic                 overflow;
    } t_shape;

    // Tracks the polygon being built and the results still owed by the block.
    class polygon_scoreboard;
        t_coord               anchor_x, anchor_y;
        t_coord               prev_x, prev_y, prev_z;
        int unsigned          vertex_count;
        logic [LEN_BITS-1:0]  length_sum;
        t_cross               shoelace_sum;
        t_shape               pending_shapes[$];
        int unsigned          mismatches;
        int unsigned          shapes_checked;

        function new();
            mismatches     = 0;
            shapes_checked = 0;
            clear_polygon();
        endfunction

        function void clear_polygon();
            anchor_x     = '0;
            anchor_y     = '0;
            prev_x       = '0;
            prev_y       = '0;
            prev_z       = '0;
            vertex_count = 0;
            length_sum   = '0;
            shoelace_sum = '0;
        endfunction

        function logic [63:0] abs_diff(t_coord a, t_coord b);
            longint d;
            d = longint'(a) - longint'(b);
            return (d < 0) ? 64'(-d) : 64'(d);
        endfunction

        // floor(sqrt(v)), one root bit at a time from the top
        function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int i = 31; i >= 0; i--) begin
                trial = root | (64'd1 << i);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function longint wedge(t_coord ax, t_coord ay, t_coord bx, t_coord by);
            return longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
        endfunction

        // signed 64-bit accumulate, clamped at both rails
        function void accumulate_area(longint term);
            logic signed [64:0] wide;
            wide = $signed({shoelace_sum[63], shoelace_sum})
                 + $signed({term[63], term});
            if (wide[64] != wide[63]) begin
                shoelace_sum = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                shoelace_sum = wide[63:0];
            end
        endfunction

        function void take_vertex(t_coord x, t_coord y, t_coord z, logic is_last);
            logic [63:0]         dx, dy, dz, seg;
            logic [LEN_BITS:0]   len_wide;
            logic [63:0]         area_mag;
            t_shape              shape;
            if (vertex_count == 0) begin
                anchor_x = x;
                anchor_y = y;
            end else begin
                dx  = abs_diff(x, prev_x);
                dy  = abs_diff(y, prev_y);
                dz  = abs_diff(z, prev_z);
                seg = floor_root(dx * dx + dy * dy + dz * dz);
                len_wide = {1'b0, length_sum} + seg[LEN_BITS:0];
                length_sum = len_wide[LEN_BITS] ? {LEN_BITS{1'b1}} : len_wide[LEN_BITS-1:0];
                accumulate_area(wedge(prev_x, prev_y, x, y));
            end
            if (vertex_count <= MAX_POINTS) begin
                vertex_count++;
            end
            prev_x = x;
            prev_y = y;
            prev_z = z;
            if (is_last) begin
                // closing edge back to the first vertex counts for area only
                accumulate_area(wedge(x, y, anchor_x, anchor_y));
                area_mag = shoelace_sum[63] ? (~shoelace_sum + 64'd1) : shoelace_sum;
                if (area_mag[63]) begin
                    area_mag = {1'b0, {63{1'b1}}};
                end
                shape.length   = length_sum;
                shape.area     = area_mag[AREA_BITS-1:0];
                shape.overflow = (vertex_count > MAX_POINTS);
                pending_shapes.push_back(shape);
                clear_polygon();
            end
        endfunction

        function void check_shape(logic [LEN_BITS-1:0] length, logic [AREA_BITS-1:0] area,
                                  logic overflow);
            t_shape want;
            if (pending_shapes.size() == 0) begin
                $display("%0t: unexpected result beat, length %0d area %0d overflow %0b",
                         $time, length, area, overflow);
                mismatches++;
                return;
            end
            want = pending_shapes.pop_front();
            shapes_checked++;
            if (length !== want.length) begin
                $display("%0t: path_length expected %0d actual %0d",
                         $time, want.length, length);
                mismatches++;
            end
            if (area !== want.area) begin
                $display("%0t: enclosed_area expected %0d actual %0d",
                         $time, want.area, area);
                mismatches++;
            end
            if (overflow !== want.overflow) begin
                $display("%0t: count_overflow expected %0b actual %0b",
                         $time, want.overflow, overflow);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [IN_BITS-1:0]   i_point_x;
    logic [IN_BITS-1:0]   i_point_y;
    logic [IN_BITS-1:0]   i_point_z;
    logic                 i_last_point;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [LEN_BITS-1:0]  o_path_length;
    logic [AREA_BITS-1:0] o_enclosed_area;
    logic                 o_count_overflow;

    polygon_scoreboard scb = new();

    int          src_gap_pct  = 0;   // chance per cycle that the vertex side idles
    int          sink_gap_pct = 0;   // chance per cycle that the result side stalls
    int unsigned rx_hold_left = 0;   // cycles of forced result back-pressure left
    int unsigned cycle_count  = 0;
    int unsigned vertices_sent = 0;
    int unsigned polygons_sent = 0;

    polyline_length_polygon_area_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_z        (i_point_z),
        .i_last_point     (i_last_point),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_path_length    (o_path_length),
        .o_enclosed_area  (o_enclosed_area),
        .o_count_overflow (o_count_overflow)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, scb.pending_shapes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check the beat taken at this edge, then choose next cycle's ready.
    // A pending hold overrides the random stall so the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            scb.check_shape(o_path_length, o_enclosed_area, o_count_overflow);
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    // One vertex beat. Valid drops only while idling, so back-to-back beats keep it high.
    task automatic send_vertex(input t_coord x, input t_coord y, input t_coord z,
                               input logic is_last);
        while ($urandom_range(99) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_point_z    <= z;
        i_last_point <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
        scb.take_vertex(x, y, z, is_last);
        vertices_sent++;
        if (is_last) begin
            polygons_sent++;
        end
    endtask

    function automatic t_coord pick_coord(t_coord_style style, t_coord center);
        int v;
        case (style)
            STYLE_NEAR: begin
                v = int'($urandom_range(8191)) - 4096;
                return t_coord'(v);
            end
            STYLE_CORNERS: begin
                case ($urandom_range(4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return '1;
                    default: return t_coord'($urandom);
                endcase
            end
            STYLE_CLUSTER: begin
                // offsets may wrap near the rails; any 24-bit value is legal
                v = int'($urandom_range(65535)) - 32768;
                return center + t_coord'(v);
            end
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Mostly short polygons, now and then a long one.
    function automatic int pick_polygon_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return 1;
        end else if (roll < 70) begin
            return $urandom_range(6, 2);
        end else if (roll < 95) begin
            return $urandom_range(20, 7);
        end
        return $urandom_range(60, 21);
    endfunction

    task automatic send_polygon(input int n, input t_coord_style style);
        t_coord cx, cy, cz;
        cx = t_coord'($urandom);
        cy = t_coord'($urandom);
        cz = t_coord'($urandom);
        for (int i = 0; i < n; i++) begin
            send_vertex(pick_coord(style, cx), pick_coord(style, cy),
                        pick_coord(style, cz), (i == n - 1));
        end
    endtask

    task automatic send_random_until(input int unsigned target);
        while (vertices_sent < target) begin
            send_polygon(pick_polygon_size(), t_coord_style'($urandom_range(3)));
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_point_x    <= '0;
        i_point_y    <= '0;
        i_point_z    <= '0;
        i_last_point <= 1'b0;
        i_out_ready  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // -------- directed polygons --------
        src_gap_pct  = 24;
        sink_gap_pct = 59;
        // lone vertices: zero length, and the closing edge with itself gives zero area
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        // longest possible segment, corner to corner; collinear so no area
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        // full-range square, counterclockwise then clockwise (negative shoelace sum)
        send_vertex(COORD_MIN, COORD_MIN, '0,        1'b0);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, '0,        1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, '0,        1'b0);
        send_vertex(COORD_MAX, COORD_MIN, '1,        1'b1);
        // unit square in Q15.8
        send_vertex('0,        '0,        '0, 1'b0);
        send_vertex(COORD_ONE, '0,        '0, 1'b0);
        send_vertex(COORD_ONE, COORD_ONE, '0, 1'b0);
        send_vertex('0,        COORD_ONE, '0, 1'b1);
        // sign boundary around zero
        send_vertex('1, '1, '1, 1'b0);
        send_vertex('0, '0, '0, 1'b0);
        send_vertex(t_coord'(1), t_coord'(1), t_coord'(1), 1'b1);
        // repeated point: zero-length segment
        send_vertex('0, '0, '0, 1'b0);
        send_vertex('0, '0, '0, 1'b1);

        // -------- random, sender idles less than receiver --------
        send_random_until(380);

        // -------- random, receiver idles less than sender --------
        src_gap_pct  = 59;
        sink_gap_pct = 24;
        send_random_until(740);

        // -------- no idling; first a long result stall while tiny polygons keep coming,
        // so a second result waits inside and the vertex side gets stalled --------
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        rx_hold_left = HOLD_CYCLES;
        for (int i = 0; i < 16; i++) begin
            send_polygon($urandom_range(2, 1), t_coord_style'($urandom_range(3)));
        end
        send_random_until(TOTAL_VERTICES);

        i_in_valid <= 1'b0;
        while (scb.pending_shapes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d vertices in %0d polygons, %0d results checked",
                 vertices_sent, polygons_sent, scb.shapes_checked);
        $display("idle mixes 24/59, 59/24 and 0/0, plus a %0d-cycle result stall",
                 HOLD_CYCLES);
        if (scb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/plpa_pkg.sv
design/polyline_length_polygon_area_unit.sv
sim/tb_top.sv
